@@ rtl/core/sha_pkg.sv @@
`timescale 1ns / 1ps
// Slot handle allocator: shared types and field widths.
// Used by slot_handle_allocator_core, slot_alloc_checker and the testbench top; depends on nothing.
package sha_pkg;

  localparam int HANDLE_W  = 6;
  localparam int PAYLOAD_W = 64;

  typedef enum logic [1:0] {
    FUNC_REGISTER   = 2'd0,
    FUNC_UNREGISTER = 2'd1,
    FUNC_GET        = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]           func;
    logic [HANDLE_W-1:0]  handle_in;
    logic [PAYLOAD_W-1:0] payload_in;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [HANDLE_W-1:0]  handle_out;
    logic [PAYLOAD_W-1:0] payload_out;
  } rsp_t;

endpackage

@@ rtl/core/slot_handle_allocator_core.sv @@
`timescale 1ns / 1ps
// Slot handle allocator top level: control, counters and result register.
// Depends on sha_pkg and sha_ram.
//
// Usage:
//   Request channel (req_valid_i / req_stall_o / req_i) carries one operation:
//   register (store payload, grant a handle), unregister (release a handle)
//   or get (read back the payload of an occupied handle). Every request gives
//   exactly one response on (rsp_valid_o / rsp_stall_i / rsp_o).
//   A transfer happens on a rising edge with valid high and stall low.
//
// Timing:
//   On the accept edge the reads of the slot table and of the free stack top
//   are launched and the request enters the execute state; the edge that
//   leaves the execute state does the read-modify-write and loads the
//   response register. The slot RAM read is registered ahead of its
//   write-back, and a new request is accepted only in the idle state, so a
//   request is not taken before the last one has left execute. The response
//   is valid right after the edge that leaves the execute state.
//   The response register lets a new request be accepted while the previous
//   response waits; if the receiver stalls, the next request waits in the
//   execute state until the response register drains.
//
// Reset: asynchronous, active low. Counters and handshake state clear; the
//   RAMs are not cleared (entries at or above the high-water mark are never
//   trusted, and the occupied flag lives next to the payload in the slot RAM).
module slot_handle_allocator_core #(
  parameter int MAX_SLOTS    = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  sha_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output sha_pkg::rsp_t rsp_o
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  // handle arithmetic width: wide enough for a port handle and a slot index
  localparam int HW     = (SLOT_W > sha_pkg::HANDLE_W) ? SLOT_W : sha_pkg::HANDLE_W;
  localparam int CMP_W  = HW + 1;
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_SLOTS);

  sha_pkg::state_e state_q, state_d;
  sha_pkg::req_t   req_q;
  sha_pkg::rsp_t   rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;
  logic [CNT_W-1:0] free_q, free_d;   // free stack depth
  logic [CNT_W-1:0] used_q, used_d;   // high-water mark

  logic req_accept;
  logic exec_done;

  // slot RAM: {occupied, payload}
  logic                    slot_we;
  logic [SLOT_W-1:0]       slot_waddr;
  logic [PAYLOAD_BITS:0]   slot_wdata;
  logic [SLOT_W-1:0]       slot_raddr;
  logic [PAYLOAD_BITS:0]   slot_rdata;

  // free stack RAM
  logic                    stk_we;
  logic [SLOT_W-1:0]       stk_waddr;
  logic [SLOT_W-1:0]       stk_wdata;
  logic [SLOT_W-1:0]       stk_raddr;
  logic [SLOT_W-1:0]       stk_rdata;

  logic [HW-1:0]    hin_ext;     // handle of incoming request
  logic [HW-1:0]    hq_ext;      // handle of request in execute
  logic [HW-1:0]    slot_ext;
  logic [CNT_W-1:0] free_dec;
  logic [SLOT_W-1:0] grant_idx;
  logic             handle_ok;

  assign req_accept = req_valid_i && !req_stall_o;
  assign exec_done  = (state_q == sha_pkg::ST_EXEC) && (!rsp_valid_q || !rsp_stall_i);

  // read addresses come straight off the request at the accept edge
  assign hin_ext    = HW'(req_i.handle_in);
  assign free_dec   = free_q - CNT_W'(1);
  assign slot_raddr = hin_ext[SLOT_W-1:0];
  assign stk_raddr  = free_dec[SLOT_W-1:0];

  sha_ram #(
    .WIDTH (PAYLOAD_BITS + 1),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (req_accept),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  sha_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (req_accept),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Writes land on the exec edge; the next read is launched no earlier than
  // the edge after, so the FSM itself is the interlock and no bypass is needed.
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha_pkg::ST_IDLE;
      rsp_valid_q <= 1'b0;
      free_q      <= '0;
      used_q      <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      free_q      <= free_d;
      used_q      <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_done) begin
      rsp_q <= rsp_d;
    end
  end

  assign hq_ext    = HW'(req_q.handle_in);
  // beyond the high-water mark the RAM word was never written: check range first
  assign handle_ok = (CMP_W'(hq_ext) < CMP_W'(used_q)) && slot_rdata[PAYLOAD_BITS];

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    free_d      = free_q;
    used_d      = used_q;
    rsp_d       = '0;
    rsp_d.status = sha_pkg::STATUS_INVALID;
    slot_we     = 1'b0;
    slot_waddr  = hq_ext[SLOT_W-1:0];
    slot_wdata  = '0;
    stk_we      = 1'b0;
    stk_waddr   = free_q[SLOT_W-1:0];
    stk_wdata   = hq_ext[SLOT_W-1:0];
    grant_idx   = used_q[SLOT_W-1:0];
    slot_ext    = '0;

    if (rsp_valid_q && !rsp_stall_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        if (req_accept) begin
          state_d = sha_pkg::ST_EXEC;
        end
      end
      sha_pkg::ST_EXEC: begin
        if (exec_done) begin
          state_d     = sha_pkg::ST_IDLE;
          rsp_valid_d = 1'b1;
          unique case (req_q.func)
            sha_pkg::FUNC_REGISTER: begin
              // recycled slot first (LIFO), else next never-used slot
              if (free_q != '0) begin
                grant_idx = stk_rdata;
                free_d    = free_dec;
              end else if (used_q < MaxCnt) begin
                grant_idx = used_q[SLOT_W-1:0];
                used_d    = used_q + CNT_W'(1);
              end
              if ((free_q != '0) || (used_q < MaxCnt)) begin
                slot_we           = 1'b1;
                slot_waddr        = grant_idx;
                slot_wdata        = {1'b1, req_q.payload_in[PAYLOAD_BITS-1:0]};
                slot_ext          = HW'(grant_idx);
                rsp_d.status      = sha_pkg::STATUS_OK;
                rsp_d.handle_out  = slot_ext[sha_pkg::HANDLE_W-1:0];
              end else begin
                rsp_d.status = sha_pkg::STATUS_FULL;
              end
            end
            sha_pkg::FUNC_UNREGISTER: begin
              if (handle_ok) begin
                slot_we      = 1'b1;
                slot_wdata   = '0;
                rsp_d.status = sha_pkg::STATUS_OK;
                if (free_q < MaxCnt) begin
                  stk_we = 1'b1;
                  free_d = free_q + CNT_W'(1);
                end
              end
            end
            sha_pkg::FUNC_GET: begin
              if (handle_ok) begin
                rsp_d.status      = sha_pkg::STATUS_OK;
                rsp_d.payload_out =
                  sha_pkg::PAYLOAD_W'(slot_rdata[PAYLOAD_BITS-1:0]);
              end
            end
            default: begin
              rsp_d.status = sha_pkg::STATUS_INVALID;
            end
          endcase
        end
      end
      default: begin
        state_d = sha_pkg::ST_IDLE;
      end
    endcase
  end

  assign req_stall_o = (state_q != sha_pkg::ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= MaxCnt)
    else $error("high-water mark beyond table size");

  a_free_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= used_q)
    else $error("free stack deeper than slots ever used");

  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q == sha_pkg::ST_EXEC))
    else $error("response raised without an executed request");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> (state_q == sha_pkg::ST_EXEC))
    else $error("accepted request did not enter execute");

endmodule

@@ rtl/core/sha_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; used for the slot table and the free stack.
module sha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/slot_alloc_checker.sv @@
`timescale 1ns / 1ps
// Response checker for slot_handle_allocator_core: tracks slot table state per request.
// Depends on sha_pkg; instantiated beside the block by tb_slot_handle_allocator_core.
module slot_alloc_checker
  import sha_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_stall_i,
  input  req_t             req_i,
  input  logic             rsp_valid_i,
  input  logic             rsp_stall_i,
  input  rsp_t             rsp_i,
  output int unsigned      mismatch_cnt_o,
  output int unsigned      owed_cnt_o,
  output logic [SLOTS-1:0] live_slots_o
);

  logic [SLOTS-1:0]     occupied = '0;
  logic [PAYLOAD_W-1:0] slot_data [SLOTS];
  logic [HANDLE_W-1:0]  free_lifo [SLOTS];
  int unsigned          free_depth = 0;
  int unsigned          high_water = 0;
  int unsigned          mismatch_cnt = 0;
  int unsigned          rsp_seq = 0;
  rsp_t                 owed_rsp_q [$];

  assign mismatch_cnt_o = mismatch_cnt;
  assign owed_cnt_o     = owed_rsp_q.size();
  assign live_slots_o   = occupied;

  // Applies one request to the tracked table and returns the response it owes.
  function automatic rsp_t slot_table_step(input req_t r);
    rsp_t                a;
    logic [HANDLE_W-1:0] slot;
    bit                  granted;
    a        = '0;
    a.status = STATUS_INVALID;
    slot     = '0;
    granted  = 1'b0;
    case (r.func)
      FUNC_REGISTER: begin
        // freed slots first (LIFO), then the next never-used one
        if (free_depth > 0) begin
          free_depth--;
          slot    = free_lifo[free_depth];
          granted = 1'b1;
        end else if (high_water < SLOTS) begin
          slot    = HANDLE_W'(high_water);
          high_water++;
          granted = 1'b1;
        end
        if (granted) begin
          occupied[slot]  = 1'b1;
          slot_data[slot] = r.payload_in;
          a.status        = STATUS_OK;
          a.handle_out    = slot;
        end else begin
          a.status = STATUS_FULL;
        end
      end
      FUNC_UNREGISTER: begin
        if (r.handle_in < high_water && occupied[r.handle_in]) begin
          occupied[r.handle_in]  = 1'b0;
          slot_data[r.handle_in] = '0;
          if (free_depth < SLOTS) begin
            free_lifo[free_depth] = r.handle_in;
            free_depth++;
          end
          a.status = STATUS_OK;
        end
      end
      FUNC_GET: begin
        if (r.handle_in < high_water && occupied[r.handle_in]) begin
          a.status      = STATUS_OK;
          a.payload_out = slot_data[r.handle_in];
        end
      end
      default: ;  // undefined code: invalid, no state change
    endcase
    return a;
  endfunction

  // Appends an expected response at the tail of the owed list.
  task automatic owe_rsp(input rsp_t want);
    owed_rsp_q.insert(owed_rsp_q.size(), want);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH rsp #%0d: %s", $time, rsp_seq, msg);
    mismatch_cnt++;
  endtask

  task automatic check_rsp(input rsp_t got);
    rsp_t want;
    if (owed_rsp_q.size() == 0) begin
      report_mismatch($sformatf("response %h with no request outstanding", got));
      return;
    end
    want = owed_rsp_q.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.handle_out !== want.handle_out)
      report_mismatch($sformatf("handle_out %0d, want %0d", got.handle_out, want.handle_out));
    if (got.payload_out !== want.payload_out)
      report_mismatch($sformatf("payload_out %h, want %h", got.payload_out, want.payload_out));
  endtask

  // Response side is checked before the same-edge request is predicted: a
  // request can never be answered on its own accept edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occupied   = '0;
      free_depth = 0;
      high_water = 0;
      owed_rsp_q.delete();
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        check_rsp(rsp_i);
        rsp_seq++;
      end
      if (req_valid_i && !req_stall_i) owe_rsp(slot_table_step(req_i));
    end
  end

endmodule

@@ tb/tb_slot_handle_allocator_core.sv @@
`timescale 1ns / 1ps
// Testbench top for slot_handle_allocator_core: clock, reset, request stimulus and verdict.
// Depends on sha_pkg, slot_handle_allocator_core and slot_alloc_checker.
module tb_slot_handle_allocator_core;
  import sha_pkg::*;

  localparam int SLOTS         = 64;
  localparam int RAND_PHASES   = 7;
  localparam int PHASE_ITEMS   = 150;
  localparam int STUCK_LIMIT   = 2000;  // cycles with no transfer on either channel
  localparam int IDLE_PCT      = 22;
  localparam int LIVE_PICK_PCT = 80;

  // func code the block must reject; not a member of func_e
  localparam logic [1:0] FUNC_UNDEFINED = 2'd3;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic req_valid_i = 1'b0;
  req_t req_i       = '0;
  logic rsp_stall_i = 1'b0;
  logic req_stall_o;
  logic rsp_valid_o;
  rsp_t rsp_o;

  // set during one random phase to run both sides with no gaps at all
  bit quiet = 1'b0;

  int unsigned      mismatch_cnt;
  int unsigned      owed_cnt;
  logic [SLOTS-1:0] live_slots;
  int unsigned      stuck_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  slot_handle_allocator_core #(
    .MAX_SLOTS   (SLOTS),
    .PAYLOAD_BITS(PAYLOAD_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  slot_alloc_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid_i),
    .req_stall_i   (req_stall_o),
    .req_i         (req_i),
    .rsp_valid_i   (rsp_valid_o),
    .rsp_stall_i   (rsp_stall_i),
    .rsp_i         (rsp_o),
    .mismatch_cnt_o(mismatch_cnt),
    .owed_cnt_o    (owed_cnt),
    .live_slots_o  (live_slots)
  );

  // Receiver back-pressure: random stall, changed on the falling edge only.
  always @(negedge clk_i) begin
    rsp_stall_i <= rst_ni && !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  always @(posedge clk_i) begin
    if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i) || !rst_ni) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic req_t mk_req(input logic [1:0] fn, input logic [HANDLE_W-1:0] h,
                                  input logic [PAYLOAD_W-1:0] d);
    req_t r;
    r.func       = fn;
    r.handle_in  = h;
    r.payload_in = d;
    return r;
  endfunction

  // Mostly a handle the table currently holds, so unregister/get get past the
  // bounds check; otherwise any handle, which covers stale and out-of-range ones.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned start;
    start = $urandom_range(SLOTS - 1);
    if ($urandom_range(99) < LIVE_PICK_PCT)
      for (int i = 0; i < SLOTS; i++)
        if (live_slots[(start + i) % SLOTS]) return HANDLE_W'((start + i) % SLOTS);
    return HANDLE_W'($urandom_range(SLOTS - 1));
  endfunction

  // Fill phases lean on register so the table runs into full; drain phases
  // lean on unregister so freed handles pile up on the free stack.
  function automatic req_t rand_req(input bit filling);
    int unsigned          pick;
    logic [1:0]           fn;
    logic [PAYLOAD_W-1:0] data;
    pick = $urandom_range(99);
    if (filling) begin
      if (pick < 60)      fn = FUNC_REGISTER;
      else if (pick < 85) fn = FUNC_GET;
      else if (pick < 95) fn = FUNC_UNREGISTER;
      else                fn = FUNC_UNDEFINED;
    end else begin
      if (pick < 15)      fn = FUNC_REGISTER;
      else if (pick < 40) fn = FUNC_GET;
      else if (pick < 95) fn = FUNC_UNREGISTER;
      else                fn = FUNC_UNDEFINED;
    end
    pick = $urandom_range(99);
    if (pick < 10)      data = '0;
    else if (pick < 20) data = '1;
    else                data = {$urandom, $urandom};
    return mk_req(fn, pick_handle(), data);
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept.
  // Valid is only ever raised between requests, never dropped while stalled.
  task automatic issue_req(input req_t item);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= item;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // --- directed part ---
    // empty table: everything is beyond the high-water mark
    issue_req(mk_req(FUNC_GET,        6'd0,  '0));
    issue_req(mk_req(FUNC_UNREGISTER, 6'd63, '1));
    issue_req(mk_req(FUNC_UNDEFINED,  6'd0,  '0));
    // fresh slots 0, 1, 2 with payload extremes
    issue_req(mk_req(FUNC_REGISTER,   6'd63, '1));
    issue_req(mk_req(FUNC_REGISTER,   6'd0,  '0));
    issue_req(mk_req(FUNC_REGISTER,   6'd21, 64'h8000_0000_0000_0001));
    issue_req(mk_req(FUNC_GET,        6'd0,  '0));
    issue_req(mk_req(FUNC_GET,        6'd1,  '1));
    issue_req(mk_req(FUNC_GET,        6'd2,  '0));
    // release, then a double release and a read of the freed slot
    issue_req(mk_req(FUNC_UNREGISTER, 6'd1,  '0));
    issue_req(mk_req(FUNC_UNREGISTER, 6'd1,  '0));
    issue_req(mk_req(FUNC_GET,        6'd1,  '0));
    issue_req(mk_req(FUNC_UNREGISTER, 6'd0,  '0));
    // LIFO reuse: 0 comes back first, then 1, then a new slot 3
    issue_req(mk_req(FUNC_REGISTER,   6'd0,  64'h5555_AAAA_5555_AAAA));
    issue_req(mk_req(FUNC_REGISTER,   6'd0,  64'hAAAA_5555_AAAA_5555));
    issue_req(mk_req(FUNC_REGISTER,   6'd0,  64'h0123_4567_89AB_CDEF));
    issue_req(mk_req(FUNC_GET,        6'd0,  '0));
    issue_req(mk_req(FUNC_GET,        6'd1,  '0));
    issue_req(mk_req(FUNC_GET,        6'd3,  '0));
    // handle above the high-water mark, and undefined code with all bits set
    issue_req(mk_req(FUNC_GET,        6'd63, '0));
    issue_req(mk_req(FUNC_UNREGISTER, 6'd4,  '0));
    issue_req(mk_req(FUNC_UNDEFINED,  6'd63, '1));

    // --- random part: alternating fill and drain phases ---
    for (int p = 0; p < RAND_PHASES; p++) begin
      quiet = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) issue_req(rand_req(p % 2 == 0));
    end
    quiet = 1'b0;
    req_valid_i <= 1'b0;

    // drain outstanding responses; the watchdog covers a response that never comes
    while (owed_cnt != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sha_pkg.sv
rtl/core/sha_ram.sv
rtl/core/slot_handle_allocator_core.sv
tb/slot_alloc_checker.sv
tb/tb_slot_handle_allocator_core.sv
